// File: design/tprq_pkg.sv
`timescale 1ns / 1ps

package tprq_pkg;

	localparam int KIND_W = 2;

	// operation codes carried on the kind field
	localparam logic [KIND_W-1:0] KIND_INSERT     = 2'd0;
	localparam logic [KIND_W-1:0] KIND_POP_HEAD   = 2'd1;
	localparam logic [KIND_W-1:0] KIND_REMOVE_SRC = 2'd2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_INS,
		ST_INS_PUT,
		ST_REM,
		ST_HEAD,
		ST_EMIT
	} seq_state_t;

	typedef struct packed {
		logic greater;
		logic src_match;
	} cmp_res_t;

endpackage

// File: design/tprq_keycmp.sv
`timescale 1ns / 1ps

module tprq_keycmp #(
	parameter int STAMP_BITS  = 32,
	parameter int SOURCE_BITS = 8
) (
	input  logic [STAMP_BITS-1:0]  ent_stamp,
	input  logic [SOURCE_BITS-1:0] ent_source,
	input  logic [STAMP_BITS-1:0]  new_stamp,
	input  logic [SOURCE_BITS-1:0] new_source,
	output tprq_pkg::cmp_res_t     res
);

	always_comb begin
		res.src_match = (ent_source == new_source);
		res.greater   = (ent_stamp > new_stamp) ||
				((ent_stamp == new_stamp) && (ent_source > new_source));
	end

endmodule

// File: design/tprq_store.sv
`timescale 1ns / 1ps

module tprq_store #(
	parameter int DEPTH = 16,
	parameter int ENT_W = 56
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [ENT_W-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [ENT_W-1:0]         rd_data
);

	logic [ENT_W-1:0] mem_q [DEPTH];
	logic [ENT_W-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// File: design/tprq_seq.sv
`timescale 1ns / 1ps

module tprq_seq #(
	parameter int DEPTH        = 16,
	parameter int STAMP_BITS   = 32,
	parameter int SOURCE_BITS  = 8,
	parameter int PAYLOAD_BITS = 16
) (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     in_valid,
	output logic                                     in_stall,
	input  logic [tprq_pkg::KIND_W-1:0]              kind,
	input  logic [STAMP_BITS-1:0]                    stamp,
	input  logic [SOURCE_BITS-1:0]                   source_id,
	input  logic [PAYLOAD_BITS-1:0]                  payload,
	output logic                                     out_valid,
	input  logic                                     out_stall,
	output logic                                     accepted,
	output logic                                     overflow,
	output logic                                     head_valid,
	output logic [STAMP_BITS-1:0]                    head_stamp,
	output logic [SOURCE_BITS-1:0]                   head_source,
	output logic [PAYLOAD_BITS-1:0]                  head_payload,
	output logic [$clog2(DEPTH+1)-1:0]               occupancy,
	output logic                                     mem_wr_en,
	output logic [$clog2(DEPTH)-1:0]                 mem_wr_addr,
	output logic [STAMP_BITS+SOURCE_BITS+PAYLOAD_BITS-1:0] mem_wr_data,
	output logic                                     mem_rd_en,
	output logic [$clog2(DEPTH)-1:0]                 mem_rd_addr,
	input  logic [STAMP_BITS+SOURCE_BITS+PAYLOAD_BITS-1:0] mem_rd_data
);

	localparam int IDX_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int ENT_W = STAMP_BITS + SOURCE_BITS + PAYLOAD_BITS;

	tprq_pkg::seq_state_t state_q, state_d;

	logic [tprq_pkg::KIND_W-1:0] kind_q;
	logic [STAMP_BITS-1:0]       stamp_q;
	logic [SOURCE_BITS-1:0]      src_q;
	logic [PAYLOAD_BITS-1:0]     pay_q;
	logic [CNT_W-1:0]            count_q;
	logic [IDX_W-1:0]            ptr_q;
	logic                        found_q;
	logic                        acc_q;
	logic                        ovf_q;

	logic                        out_valid_q;
	logic                        accepted_q;
	logic                        overflow_q;
	logic                        head_valid_q;
	logic [STAMP_BITS-1:0]       head_stamp_q;
	logic [SOURCE_BITS-1:0]      head_source_q;
	logic [PAYLOAD_BITS-1:0]     head_payload_q;
	logic [CNT_W-1:0]            occupancy_q;

	logic                        in_acc;
	logic                        out_free;
	logic                        full;
	logic                        empty;
	logic                        last;
	logic                        hit;
	logic [IDX_W-1:0]            last_idx;
	logic [IDX_W-1:0]            ptr_next;
	logic [STAMP_BITS-1:0]       ent_stamp;
	logic [SOURCE_BITS-1:0]      ent_source;
	logic [PAYLOAD_BITS-1:0]     ent_payload;
	logic [ENT_W-1:0]            new_entry;
	tprq_pkg::cmp_res_t          cmp;

	assign ent_stamp   = mem_rd_data[ENT_W-1 -: STAMP_BITS];
	assign ent_source  = mem_rd_data[PAYLOAD_BITS +: SOURCE_BITS];
	assign ent_payload = mem_rd_data[PAYLOAD_BITS-1:0];
	assign new_entry   = {stamp_q, src_q, pay_q};

	tprq_keycmp #(
		.STAMP_BITS (STAMP_BITS),
		.SOURCE_BITS(SOURCE_BITS)
	) u_keycmp (
		.ent_stamp (ent_stamp),
		.ent_source(ent_source),
		.new_stamp (stamp_q),
		.new_source(src_q),
		.res       (cmp)
	);

	assign in_stall = (state_q != tprq_pkg::ST_IDLE);
	assign in_acc   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;
	assign full     = (count_q == CNT_W'(DEPTH));
	assign empty    = (count_q == '0);
	assign last_idx = IDX_W'(count_q - CNT_W'(1));
	assign ptr_next = ptr_q + IDX_W'(1);
	assign last     = ((CNT_W'(ptr_q) + CNT_W'(1)) == count_q);
	// head removal always hits slot zero; source removal takes the first match
	assign hit      = (kind_q == tprq_pkg::KIND_POP_HEAD) ? (ptr_q == '0) : cmp.src_match;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			tprq_pkg::ST_IDLE: begin
				if (in_acc) begin
					case (kind)
						tprq_pkg::KIND_INSERT: begin
							if (full) begin
								state_d = tprq_pkg::ST_HEAD;
							end else if (empty) begin
								state_d = tprq_pkg::ST_INS_PUT;
							end else begin
								state_d = tprq_pkg::ST_INS;
							end
						end
						tprq_pkg::KIND_POP_HEAD, tprq_pkg::KIND_REMOVE_SRC: begin
							state_d = empty ? tprq_pkg::ST_HEAD : tprq_pkg::ST_REM;
						end
						default: state_d = tprq_pkg::ST_HEAD;
					endcase
				end
			end
			tprq_pkg::ST_INS: begin
				if (!cmp.greater) begin
					state_d = tprq_pkg::ST_HEAD;
				end else if (ptr_q == '0) begin
					state_d = tprq_pkg::ST_INS_PUT;
				end
			end
			tprq_pkg::ST_INS_PUT: state_d = tprq_pkg::ST_HEAD;
			tprq_pkg::ST_REM: begin
				if (last) begin
					state_d = tprq_pkg::ST_HEAD;
				end
			end
			tprq_pkg::ST_HEAD: state_d = tprq_pkg::ST_EMIT;
			tprq_pkg::ST_EMIT: begin
				if (out_free) begin
					state_d = tprq_pkg::ST_IDLE;
				end
			end
			default: state_d = tprq_pkg::ST_IDLE;
		endcase
	end

	// store port control
	always_comb begin
		mem_rd_en   = 1'b0;
		mem_rd_addr = '0;
		mem_wr_en   = 1'b0;
		mem_wr_addr = '0;
		mem_wr_data = new_entry;
		case (state_q)
			tprq_pkg::ST_IDLE: begin
				if (in_acc && !empty) begin
					mem_rd_en   = 1'b1;
					mem_rd_addr = (kind == tprq_pkg::KIND_INSERT) ? last_idx : '0;
				end
			end
			tprq_pkg::ST_INS: begin
				// walk down from the tail, moving larger keys up one slot
				mem_wr_en   = 1'b1;
				mem_wr_addr = ptr_next;
				if (cmp.greater) begin
					mem_wr_data = mem_rd_data;
					if (ptr_q != '0) begin
						mem_rd_en   = 1'b1;
						mem_rd_addr = ptr_q - IDX_W'(1);
					end
				end
			end
			tprq_pkg::ST_INS_PUT: begin
				mem_wr_en   = 1'b1;
				mem_wr_addr = '0;
			end
			tprq_pkg::ST_REM: begin
				// after the removed slot, move each entry down one place
				if (found_q) begin
					mem_wr_en   = 1'b1;
					mem_wr_addr = ptr_q - IDX_W'(1);
					mem_wr_data = mem_rd_data;
				end
				if (!last) begin
					mem_rd_en   = 1'b1;
					mem_rd_addr = ptr_next;
				end
			end
			tprq_pkg::ST_HEAD: begin
				mem_rd_en   = 1'b1;
				mem_rd_addr = '0;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= tprq_pkg::ST_IDLE;
			count_q     <= '0;
			found_q     <= 1'b0;
			acc_q       <= 1'b0;
			ovf_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			case (state_q)
				tprq_pkg::ST_IDLE: begin
					if (in_acc) begin
						found_q <= 1'b0;
						acc_q   <= 1'b0;
						ovf_q   <= (kind == tprq_pkg::KIND_INSERT) && full;
					end
				end
				tprq_pkg::ST_INS: begin
					if (!cmp.greater) begin
						count_q <= count_q + CNT_W'(1);
						acc_q   <= 1'b1;
					end
				end
				tprq_pkg::ST_INS_PUT: begin
					count_q <= count_q + CNT_W'(1);
					acc_q   <= 1'b1;
				end
				tprq_pkg::ST_REM: begin
					if (!found_q && hit) begin
						found_q <= 1'b1;
					end
					if (last && (found_q || hit)) begin
						count_q <= count_q - CNT_W'(1);
						acc_q   <= 1'b1;
					end
				end
				default: ;
			endcase
			if (state_q == tprq_pkg::ST_EMIT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			kind_q  <= kind;
			stamp_q <= stamp;
			src_q   <= source_id;
			pay_q   <= payload;
			ptr_q   <= (kind == tprq_pkg::KIND_INSERT) ? last_idx : '0;
		end else if (state_q == tprq_pkg::ST_INS && cmp.greater && ptr_q != '0) begin
			ptr_q <= ptr_q - IDX_W'(1);
		end else if (state_q == tprq_pkg::ST_REM && !last) begin
			ptr_q <= ptr_next;
		end
		if (state_q == tprq_pkg::ST_EMIT && out_free) begin
			accepted_q     <= acc_q;
			overflow_q     <= ovf_q;
			head_valid_q   <= !empty;
			head_stamp_q   <= empty ? '0 : ent_stamp;
			head_source_q  <= empty ? '0 : ent_source;
			head_payload_q <= empty ? '0 : ent_payload;
			occupancy_q    <= count_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign accepted     = accepted_q;
	assign overflow     = overflow_q;
	assign head_valid   = head_valid_q;
	assign head_stamp   = head_stamp_q;
	assign head_source  = head_source_q;
	assign head_payload = head_payload_q;
	assign occupancy    = occupancy_q;

endmodule

// File: design/timestamp_priority_request_queue_top.sv
`timescale 1ns / 1ps
// Sorted request queue keyed by (stamp, source_id), smallest key at the head.
// Input channel: in_valid / in_stall with kind, stamp, source_id, payload.
// kind selects insert, remove head, or remove the first entry of source_id.
// Output channel: out_valid / out_stall, one result transaction per input
// transaction: accepted, overflow, head entry after the operation, occupancy.
// The entries sit in a single-port-write, registered-read store and one key
// comparator is reused while a sequencer walks the entries one per cycle.
// An insert walks from the tail and stops at the first key not larger;
// a removal walks every entry; a full-queue insert, an empty removal or an
// unused kind skips the walk.
// The result is registered and visible after the walk finishes, once the
// head slot is read back; in_stall is high until it is loaded.
// A stalled result holds in the output register while the next input
// transaction is taken; the following result waits until that one drains.
// Reset empties the queue (occupancy 0) and drops any pending result; the
// store contents are not cleared, only slots below the occupancy are read.
module timestamp_priority_request_queue_top #(
	parameter int DEPTH        = 16,
	parameter int STAMP_BITS   = 32,
	parameter int SOURCE_BITS  = 8,
	parameter int PAYLOAD_BITS = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [tprq_pkg::KIND_W-1:0]    kind,
	input  logic [STAMP_BITS-1:0]          stamp,
	input  logic [SOURCE_BITS-1:0]         source_id,
	input  logic [PAYLOAD_BITS-1:0]        payload,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic                           accepted,
	output logic                           overflow,
	output logic                           head_valid,
	output logic [STAMP_BITS-1:0]          head_stamp,
	output logic [SOURCE_BITS-1:0]         head_source,
	output logic [PAYLOAD_BITS-1:0]        head_payload,
	output logic [$clog2(DEPTH+1)-1:0]     occupancy
);

	localparam int IDX_W = $clog2(DEPTH);
	localparam int ENT_W = STAMP_BITS + SOURCE_BITS + PAYLOAD_BITS;

	logic             mem_wr_en;
	logic [IDX_W-1:0] mem_wr_addr;
	logic [ENT_W-1:0] mem_wr_data;
	logic             mem_rd_en;
	logic [IDX_W-1:0] mem_rd_addr;
	logic [ENT_W-1:0] mem_rd_data;

	tprq_store #(
		.DEPTH(DEPTH),
		.ENT_W(ENT_W)
	) u_store (
		.clk    (clk),
		.wr_en  (mem_wr_en),
		.wr_addr(mem_wr_addr),
		.wr_data(mem_wr_data),
		.rd_en  (mem_rd_en),
		.rd_addr(mem_rd_addr),
		.rd_data(mem_rd_data)
	);

	tprq_seq #(
		.DEPTH       (DEPTH),
		.STAMP_BITS  (STAMP_BITS),
		.SOURCE_BITS (SOURCE_BITS),
		.PAYLOAD_BITS(PAYLOAD_BITS)
	) u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.kind        (kind),
		.stamp       (stamp),
		.source_id   (source_id),
		.payload     (payload),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.accepted    (accepted),
		.overflow    (overflow),
		.head_valid  (head_valid),
		.head_stamp  (head_stamp),
		.head_source (head_source),
		.head_payload(head_payload),
		.occupancy   (occupancy),
		.mem_wr_en   (mem_wr_en),
		.mem_wr_addr (mem_wr_addr),
		.mem_wr_data (mem_wr_data),
		.mem_rd_en   (mem_rd_en),
		.mem_rd_addr (mem_rd_addr),
		.mem_rd_data (mem_rd_data)
	);

endmodule

// File: dv/tb_timestamp_priority_request_queue_top.sv
`timescale 1ns / 1ps

module tb_timestamp_priority_request_queue_top;

	localparam int DEPTH        = 16;
	localparam int STAMP_BITS   = 32;
	localparam int SOURCE_BITS  = 8;
	localparam int PAYLOAD_BITS = 16;
	localparam int OCC_BITS     = $clog2(DEPTH + 1);
	localparam int RANDOM_ITEMS = 1400;
	localparam int IDLE_LIMIT   = 5000;
	localparam int TAIL_CYCLES  = 40;

	// the package leaves the fourth code unnamed; the block must ignore it
	localparam logic [tprq_pkg::KIND_W-1:0] KIND_UNUSED = 2'd3;

	typedef struct packed {
		logic                          hold_first;
		logic [tprq_pkg::KIND_W-1:0]   kind;
		logic [STAMP_BITS-1:0]         stamp;
		logic [SOURCE_BITS-1:0]        source_id;
		logic [PAYLOAD_BITS-1:0]       payload;
	} request_t;

	typedef struct packed {
		logic                    accepted;
		logic                    overflow;
		logic                    head_valid;
		logic [STAMP_BITS-1:0]   head_stamp;
		logic [SOURCE_BITS-1:0]  head_source;
		logic [PAYLOAD_BITS-1:0] head_payload;
		logic [OCC_BITS-1:0]     occupancy;
	} report_t;

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          in_valid = 1'b0;
	logic                          in_stall;
	logic [tprq_pkg::KIND_W-1:0]   kind = '0;
	logic [STAMP_BITS-1:0]         stamp = '0;
	logic [SOURCE_BITS-1:0]        source_id = '0;
	logic [PAYLOAD_BITS-1:0]       payload = '0;
	logic                          out_valid;
	logic                          out_stall = 1'b0;
	logic                          accepted;
	logic                          overflow;
	logic                          head_valid;
	logic [STAMP_BITS-1:0]         head_stamp;
	logic [SOURCE_BITS-1:0]        head_source;
	logic [PAYLOAD_BITS-1:0]       head_payload;
	logic [OCC_BITS-1:0]           occupancy;

	timestamp_priority_request_queue_top #(
		.DEPTH        (DEPTH),
		.STAMP_BITS   (STAMP_BITS),
		.SOURCE_BITS  (SOURCE_BITS),
		.PAYLOAD_BITS (PAYLOAD_BITS)
	) u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.kind         (kind),
		.stamp        (stamp),
		.source_id    (source_id),
		.payload      (payload),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.accepted     (accepted),
		.overflow     (overflow),
		.head_valid   (head_valid),
		.head_stamp   (head_stamp),
		.head_source  (head_source),
		.head_payload (head_payload),
		.occupancy    (occupancy)
	);

	// shadow copy of the sorted store, slot 0 is the head
	logic [STAMP_BITS-1:0]   sorted_stamps   [DEPTH];
	logic [SOURCE_BITS-1:0]  sorted_sources  [DEPTH];
	logic [PAYLOAD_BITS-1:0] sorted_payloads [DEPTH];
	int                      held = 0;

	request_t request_fifo[$];
	report_t  head_reports[$];
	request_t cur_req;
	int       mismatches = 0;

	function automatic logic key_above(logic [STAMP_BITS-1:0] sa, logic [SOURCE_BITS-1:0] ra,
		logic [STAMP_BITS-1:0] sb, logic [SOURCE_BITS-1:0] rb);
		return (sa > sb) || (sa == sb && ra > rb);
	endfunction

	function automatic void drop_entry(int pos);
		for (int i = pos; i < held - 1; i++) begin
			sorted_stamps[i]   = sorted_stamps[i + 1];
			sorted_sources[i]  = sorted_sources[i + 1];
			sorted_payloads[i] = sorted_payloads[i + 1];
		end
		held--;
	endfunction

	// apply one request to the shadow store and build the report it yields
	function automatic report_t queue_op_report(request_t r);
		report_t rep;
		int      pos;
		logic    found;
		rep = '0;
		found = 1'b0;
		pos = held;
		case (r.kind)
			tprq_pkg::KIND_INSERT: begin
				if (held >= DEPTH) begin
					rep.overflow = 1'b1;
				end else begin
					for (int i = 0; i < held; i++) begin
						if (!found && key_above(sorted_stamps[i], sorted_sources[i],
							r.stamp, r.source_id)) begin
							pos = i;
							found = 1'b1;
						end
					end
					for (int i = held; i > pos; i--) begin
						sorted_stamps[i]   = sorted_stamps[i - 1];
						sorted_sources[i]  = sorted_sources[i - 1];
						sorted_payloads[i] = sorted_payloads[i - 1];
					end
					sorted_stamps[pos]   = r.stamp;
					sorted_sources[pos]  = r.source_id;
					sorted_payloads[pos] = r.payload;
					held++;
					rep.accepted = 1'b1;
				end
			end
			tprq_pkg::KIND_POP_HEAD: begin
				if (held > 0) begin
					drop_entry(0);
					rep.accepted = 1'b1;
				end
			end
			tprq_pkg::KIND_REMOVE_SRC: begin
				for (int i = 0; i < held; i++) begin
					if (!found && sorted_sources[i] == r.source_id) begin
						pos = i;
						found = 1'b1;
					end
				end
				if (found) begin
					drop_entry(pos);
					rep.accepted = 1'b1;
				end
			end
			default: begin
			end
		endcase
		if (held > 0) begin
			rep.head_valid   = 1'b1;
			rep.head_stamp   = sorted_stamps[0];
			rep.head_source  = sorted_sources[0];
			rep.head_payload = sorted_payloads[0];
		end
		rep.occupancy = held[OCC_BITS-1:0];
		return rep;
	endfunction

	initial begin
		forever #10 clk = ~clk;
	end

	// driver: bursts of transactions separated by random gaps
	int gap_left = 0;
	int burst_left = 0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid   <= 1'b0;
			gap_left   <= 0;
			burst_left <= 0;
		end else begin
			if (in_valid && !in_stall) begin
				head_reports.push_back(queue_op_report(cur_req));
			end
			if (!in_valid || !in_stall) begin
				if (gap_left > 0) begin
					gap_left <= gap_left - 1;
					in_valid <= 1'b0;
				end else if (request_fifo.size() > 0 &&
					!(request_fifo[0].hold_first && head_reports.size() > 0)) begin
					cur_req = request_fifo.pop_front();
					kind      <= cur_req.kind;
					stamp     <= cur_req.stamp;
					source_id <= cur_req.source_id;
					payload   <= cur_req.payload;
					in_valid  <= 1'b1;
					if (burst_left <= 1) begin
						burst_left <= $urandom_range(1, 40);
						gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
					end else begin
						burst_left <= burst_left - 1;
					end
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// result stall pattern: free-flowing, light and heavy stretches
	int stall_mode = 0;
	int stall_left = 0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall  <= 1'b0;
			stall_mode <= 0;
			stall_left <= 0;
		end else begin
			if (stall_left == 0) begin
				stall_mode <= $urandom_range(0, 2);
				stall_left <= $urandom_range(10, 80);
			end else begin
				stall_left <= stall_left - 1;
			end
			case (stall_mode)
				0:       out_stall <= 1'b0;
				1:       out_stall <= ($urandom_range(0, 3) == 0);
				default: out_stall <= ($urandom_range(0, 4) != 0);
			endcase
		end
	end

	// monitor: compare every result transaction with the oldest prediction
	report_t want;

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (head_reports.size() == 0) begin
				$error("result transaction with no request outstanding");
				mismatches++;
			end else begin
				want = head_reports.pop_front();
				if (accepted !== want.accepted) begin
					$error("accepted: expected %0d, got %0d", want.accepted, accepted);
					mismatches++;
				end
				if (overflow !== want.overflow) begin
					$error("overflow: expected %0d, got %0d", want.overflow, overflow);
					mismatches++;
				end
				if (head_valid !== want.head_valid) begin
					$error("head_valid: expected %0d, got %0d", want.head_valid, head_valid);
					mismatches++;
				end
				if (head_stamp !== want.head_stamp) begin
					$error("head_stamp: expected %0h, got %0h", want.head_stamp, head_stamp);
					mismatches++;
				end
				if (head_source !== want.head_source) begin
					$error("head_source: expected %0h, got %0h", want.head_source, head_source);
					mismatches++;
				end
				if (head_payload !== want.head_payload) begin
					$error("head_payload: expected %0h, got %0h", want.head_payload,
						head_payload);
					mismatches++;
				end
				if (occupancy !== want.occupancy) begin
					$error("occupancy: expected %0d, got %0d", want.occupancy, occupancy);
					mismatches++;
				end
			end
		end
	end

	int idle_cycles = 0;

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
				idle_cycles <= 0;
			end else if (idle_cycles >= IDLE_LIMIT) begin
				$display("Mismatches found");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	task automatic add_request(logic [tprq_pkg::KIND_W-1:0] k, logic [STAMP_BITS-1:0] s,
		logic [SOURCE_BITS-1:0] src, logic [PAYLOAD_BITS-1:0] p, logic hold);
		request_t r;
		r.hold_first = hold;
		r.kind       = k;
		r.stamp      = s;
		r.source_id  = src;
		r.payload    = p;
		request_fifo.push_back(r);
	endtask

	function automatic logic [STAMP_BITS-1:0] pick_stamp();
		int r;
		r = $urandom_range(0, 9);
		// half the time a narrow range so equal stamps collide and ties go to source
		if (r < 5)
			return $urandom_range(0, 15);
		else if (r < 8)
			return $urandom;
		else
			return 32'hffff_ffff - $urandom_range(0, 3);
	endfunction

	function automatic logic [SOURCE_BITS-1:0] pick_source();
		if ($urandom_range(0, 3) == 0)
			return SOURCE_BITS'($urandom_range(0, 255));
		return SOURCE_BITS'($urandom_range(0, 7));
	endfunction

	initial begin
		int ins_pct;
		int seg_len;
		int roll;
		int n;

		// empty queue: unused code and removals that find nothing
		add_request(KIND_UNUSED, 32'hffff_ffff, 8'hff, 16'hffff, 1'b0);
		add_request(tprq_pkg::KIND_POP_HEAD, '0, '0, '0, 1'b0);
		add_request(tprq_pkg::KIND_REMOVE_SRC, '0, 8'd0, '0, 1'b0);
		// equal keys land after, smaller source on the same stamp lands before
		add_request(tprq_pkg::KIND_INSERT, 32'd100, 8'd5, 16'h0001, 1'b0);
		add_request(tprq_pkg::KIND_INSERT, 32'd100, 8'd5, 16'h0002, 1'b0);
		add_request(tprq_pkg::KIND_INSERT, 32'd100, 8'd3, 16'h0003, 1'b0);
		add_request(tprq_pkg::KIND_INSERT, 32'd0, 8'hff, 16'hffff, 1'b0);
		add_request(tprq_pkg::KIND_INSERT, 32'hffff_ffff, 8'd0, 16'h0000, 1'b0);
		add_request(tprq_pkg::KIND_INSERT, 32'hffff_ffff, 8'hff, 16'haaaa, 1'b0);
		add_request(tprq_pkg::KIND_INSERT, 32'd0, 8'd0, 16'h5555, 1'b0);
		for (int i = 0; i < 9; i++)
			add_request(tprq_pkg::KIND_INSERT, 32'd50 + i * 20, i[7:0],
				PAYLOAD_BITS'(16'h1000 + i), 1'b0);
		// full queue refuses the insert
		add_request(tprq_pkg::KIND_INSERT, 32'd1, 8'd1, 16'hbeef, 1'b0);
		add_request(tprq_pkg::KIND_REMOVE_SRC, '0, 8'd200, '0, 1'b0);
		add_request(tprq_pkg::KIND_REMOVE_SRC, '0, 8'd5, '0, 1'b0);
		add_request(tprq_pkg::KIND_REMOVE_SRC, '0, 8'hff, '0, 1'b0);
		add_request(tprq_pkg::KIND_POP_HEAD, '0, '0, '0, 1'b0);
		add_request(KIND_UNUSED, 32'h1234_5678, 8'h5a, 16'h0f0f, 1'b0);

		// each segment picks a random insert share, so the queue fills and drains
		n = 0;
		while (n < RANDOM_ITEMS) begin
			case ($urandom_range(0, 3))
				0:       ins_pct = 15;
				1:       ins_pct = 50;
				2:       ins_pct = 80;
				default: ins_pct = 95;
			endcase
			seg_len = $urandom_range(20, 60);
			for (int j = 0; j < seg_len && n < RANDOM_ITEMS; j++) begin
				roll = $urandom_range(0, 99);
				if (roll < 2)
					add_request(KIND_UNUSED, $urandom, SOURCE_BITS'($urandom_range(0, 255)),
						PAYLOAD_BITS'($urandom_range(0, 16'hffff)), n == 700);
				else if (roll < ins_pct)
					add_request(tprq_pkg::KIND_INSERT, pick_stamp(), pick_source(),
						PAYLOAD_BITS'($urandom_range(0, 16'hffff)), n == 0 || n == 700);
				else if ($urandom_range(0, 1) == 0)
					add_request(tprq_pkg::KIND_POP_HEAD, $urandom,
						SOURCE_BITS'($urandom_range(0, 255)),
						PAYLOAD_BITS'($urandom_range(0, 16'hffff)), n == 0 || n == 700);
				else
					add_request(tprq_pkg::KIND_REMOVE_SRC, $urandom, pick_source(),
						PAYLOAD_BITS'($urandom_range(0, 16'hffff)), n == 0 || n == 700);
				n++;
			end
		end

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		wait (request_fifo.size() == 0 && !in_valid && head_reports.size() == 0);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

// File: filelist.f
design/tprq_pkg.sv
design/tprq_keycmp.sv
design/tprq_store.sv
design/tprq_seq.sv
design/timestamp_priority_request_queue_top.sv
dv/tb_timestamp_priority_request_queue_top.sv
